@@ src/owned_candidate_kway_merge_macros.svh @@
// Assertion macros for the k-way merge block
`ifndef OWNED_CANDIDATE_KWAY_MERGE_MACROS_SVH
`define OWNED_CANDIDATE_KWAY_MERGE_MACROS_SVH

// same-cycle implication, checked outside reset
`define OCKM_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ockm check failed: %m");

// next-cycle implication, checked outside reset
`define OCKM_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ockm check failed: %m");

`endif

@@ src/ockm_pkg.sv @@
// Package: types, constants and key compare for the k-way merge block
`timescale 1ns / 1ps
package ockm_pkg;

    localparam int ENT_W       = 10;
    localparam int MAX_STREAMS = 8;
    localparam int STREAM_W    = 3;
    localparam int LIST_DEPTH  = 64;
    localparam int POS_W       = 6;
    localparam int LEN_W       = 7;
    localparam int SIZE_W      = 4;
    localparam int HALF_W      = 3;
    localparam int CELL_W      = 16;

    typedef enum logic [2:0] {
        K_ENTITY  = 3'd0,
        K_LIST    = 3'd1,
        K_SETLIST = 3'd2,
        K_START   = 3'd3,
        K_NEXT    = 3'd4
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_PUSH,
        ST_HEAP,
        ST_NX0,
        ST_NX1,
        ST_NX2,
        ST_NX3,
        ST_DONE,
        SK_CHK,
        SK_ID,
        SK_CELL,
        SF_N0,
        SF_N1,
        SF_N2,
        SF_C0,
        SF_C1,
        SF_C2,
        SF_D1,
        SF_D2,
        SF_CMP
    } t_state;

    typedef struct packed {
        logic signed [21:0] x;
        logic        [21:0] z;
        logic        [19:0] y;
        logic        [31:0] order;
        logic signed [CELL_W-1:0] cz;
        logic signed [CELL_W-1:0] cy;
        logic signed [CELL_W-1:0] cx;
    } t_meta;

    typedef struct packed {
        logic signed [CELL_W-1:0] cz;
        logic signed [CELL_W-1:0] cy;
        logic signed [CELL_W-1:0] cx;
    } t_cell;

    // true when entity a orders strictly before entity b
    function automatic logic earlier(t_meta a, logic [ENT_W-1:0] ia,
                                     t_meta b, logic [ENT_W-1:0] ib);
        logic [105:0] ka;
        logic [105:0] kb;
        ka = {~a.x[21], a.x[20:0], a.z, a.y, a.order, ia};
        kb = {~b.x[21], b.x[20:0], b.z, b.y, b.order, ib};
        return ka < kb;
    endfunction

endpackage

@@ src/owned_candidate_kway_merge.sv @@
// Sequence: loads never raise busy. A next item holds busy through NX0, NX1, the list scan
// (one check with no ownership axes, else check, id and cell reads per entry examined, plus
// a final check when none is owned), NX2, NX3, a sift if the heap stays non-empty, and DONE;
// on an empty heap it goes from NX0 to DONE. A start item runs INIT, a scan and PUSH per list,
// then sifts each internal heap node. One item at a time; o_valid rises in the cycle busy falls.
// Reset (synchronous, active low) clears state, o_valid, list lengths, axes and heap size.
`timescale 1ns / 1ps
`include "owned_candidate_kway_merge_macros.svh"
module owned_candidate_kway_merge import ockm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_kind,
    input  logic [ENT_W-1:0]         i_entity_id,
    input  logic signed [21:0]       i_sec_x,
    input  logic [21:0]              i_sec_z,
    input  logic [19:0]              i_sec_y,
    input  logic [31:0]              i_order_key,
    input  logic signed [CELL_W-1:0] i_cell_x,
    input  logic signed [CELL_W-1:0] i_cell_y,
    input  logic signed [CELL_W-1:0] i_cell_z,
    input  logic [STREAM_W-1:0]      i_stream,
    input  logic [POS_W-1:0]         i_position,
    input  logic [LEN_W-1:0]         i_count,
    output logic                     o_valid,
    output logic [ENT_W-1:0]         o_candidate,
    output logic                     o_exhausted
);

    // memories
    t_meta             meta_mem [1 << ENT_W];
    logic [ENT_W-1:0]  list_mem [MAX_STREAMS * LIST_DEPTH];

    // small register files
    t_cell             r_list_cell [MAX_STREAMS];
    logic [LEN_W-1:0]  r_list_len  [MAX_STREAMS];
    logic [2:0]        r_list_axes [MAX_STREAMS];
    logic [STREAM_W-1:0] r_heap_list [MAX_STREAMS];
    logic [POS_W-1:0]  r_heap_pos  [MAX_STREAMS];
    logic [SIZE_W-1:0] r_heap_size;

    t_state            r_state, n_state, r_ret;
    logic [ENT_W-1:0]  r_lrd;
    t_meta             r_meta;
    t_cell             r_src;
    logic [SIZE_W-1:0] r_n, r_i;
    logic [HALF_W-1:0] r_h;
    logic [STREAM_W-1:0] r_s;
    logic [LEN_W-1:0]  r_pos;
    logic              r_found;
    logic [STREAM_W-1:0] r_par;
    logic [SIZE_W-1:0] r_c;
    logic [STREAM_W-1:0] r_nl;
    logic [POS_W-1:0]  r_np;
    t_meta             r_node;
    logic [ENT_W-1:0]  r_node_id;
    t_meta             r_ka;
    logic [ENT_W-1:0]  r_ida;
    logic [ENT_W-1:0]  r_cand;
    logic              r_valid;
    logic              r_exh;

    logic                                 w_acc;
    t_kind                                w_kind;
    logic                                 w_lre;
    logic [STREAM_W+POS_W-1:0]            w_laddr;
    logic [SIZE_W-1:0]                    w_c;
    logic [SIZE_W-1:0]                    w_c1;
    logic                                 w_own;
    logic                                 w_b_first;
    logic                                 w_c_first;
    logic [2:0]                           w_axes;
    t_cell                                w_lc;

    assign w_acc   = start && !busy;
    assign w_kind  = t_kind'(i_kind);
    assign busy    = (r_state != ST_IDLE);
    assign w_c     = {r_par, 1'b1};
    assign w_c1    = r_c + SIZE_W'(1);
    assign w_lc    = r_list_cell[r_s];

    assign w_own = (!r_list_axes[r_s][0] || r_meta.cx == w_lc.cx) &&
                   (!r_list_axes[r_s][1] || r_meta.cy == w_lc.cy) &&
                   (!r_list_axes[r_s][2] || r_meta.cz == w_lc.cz);
    assign w_b_first = earlier(r_meta, r_lrd, r_ka, r_ida);
    assign w_c_first = earlier(r_ka, r_ida, r_node, r_node_id);

    always_comb begin
        w_axes[0] = r_list_cell[r_i[STREAM_W-1:0]].cx > r_src.cx;
        w_axes[1] = r_list_cell[r_i[STREAM_W-1:0]].cy > r_src.cy;
        w_axes[2] = r_list_cell[r_i[STREAM_W-1:0]].cz > r_src.cz;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && w_kind == K_START) n_state = ST_INIT;
                else if (w_acc && w_kind == K_NEXT) n_state = ST_NX0;
            end
            ST_INIT: n_state = (r_i < r_n) ? SK_CHK : ST_HEAP;
            ST_PUSH: n_state = ST_INIT;
            ST_HEAP: n_state = (r_h == '0) ? ST_IDLE : SF_N0;
            ST_NX0:  n_state = (r_heap_size == '0) ? ST_DONE : ST_NX1;
            ST_NX1:  n_state = SK_CHK;
            ST_NX2:  n_state = ST_NX3;
            ST_NX3:  n_state = (r_heap_size != '0) ? SF_N0 : ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            SK_CHK: begin
                if (r_pos >= r_list_len[r_s] || r_list_axes[r_s] == 3'b000) n_state = r_ret;
                else n_state = SK_ID;
            end
            SK_ID:   n_state = SK_CELL;
            SK_CELL: n_state = w_own ? r_ret : SK_CHK;
            SF_N0:   n_state = SF_N1;
            SF_N1:   n_state = SF_N2;
            SF_N2:   n_state = SF_C0;
            SF_C0:   n_state = (w_c >= r_heap_size) ? r_ret : SF_C1;
            SF_C1:   n_state = SF_C2;
            SF_C2:   n_state = (w_c1 < r_heap_size) ? SF_D1 : SF_CMP;
            SF_D1:   n_state = SF_D2;
            SF_D2:   n_state = SF_CMP;
            SF_CMP:  n_state = w_c_first ? SF_C0 : r_ret;
            default: n_state = ST_IDLE;
        endcase
    end

    // list memory read port control
    always_comb begin
        w_lre   = 1'b0;
        w_laddr = '0;
        unique case (r_state)
            SK_CHK: begin
                w_lre   = 1'b1;
                w_laddr = {r_s, r_pos[POS_W-1:0]};
            end
            ST_NX0: begin
                w_lre   = 1'b1;
                w_laddr = {r_heap_list[0], r_heap_pos[0]};
            end
            SF_N0: begin
                w_lre   = 1'b1;
                w_laddr = {r_heap_list[r_par], r_heap_pos[r_par]};
            end
            SF_C0: begin
                w_lre   = 1'b1;
                w_laddr = {r_heap_list[w_c[STREAM_W-1:0]], r_heap_pos[w_c[STREAM_W-1:0]]};
            end
            SF_C2: begin
                w_lre   = 1'b1;
                w_laddr = {r_heap_list[w_c1[STREAM_W-1:0]], r_heap_pos[w_c1[STREAM_W-1:0]]};
            end
            default: begin
                w_lre   = 1'b0;
                w_laddr = '0;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_acc && w_kind == K_ENTITY) begin
            meta_mem[i_entity_id] <= '{x: i_sec_x, z: i_sec_z, y: i_sec_y,
                                       order: i_order_key, cz: i_cell_z,
                                       cy: i_cell_y, cx: i_cell_x};
        end
        r_meta <= meta_mem[r_lrd];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_kind == K_LIST) list_mem[{i_stream, i_position}] <= i_entity_id;
        if (w_lre) r_lrd <= list_mem[w_laddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_heap_size <= '0;
            r_valid     <= 1'b0;
            for (int k = 0; k < MAX_STREAMS; k++) begin
                r_list_len[k]  <= '0;
                r_list_axes[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_DONE);
            if (w_acc && w_kind == K_SETLIST) begin
                r_list_len[i_stream] <= (i_count > LEN_W'(LIST_DEPTH)) ?
                                        LEN_W'(LIST_DEPTH) : i_count;
            end
            if (w_acc && w_kind == K_START) r_heap_size <= '0;
            if (r_state == ST_INIT && r_i < r_n) r_list_axes[r_i[STREAM_W-1:0]] <= w_axes;
            if (r_state == ST_PUSH && r_found) r_heap_size <= r_heap_size + SIZE_W'(1);
            if (r_state == ST_NX2 && !r_found) r_heap_size <= r_heap_size - SIZE_W'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_acc && w_kind == K_SETLIST) begin
            r_list_cell[i_stream] <= '{cz: i_cell_z, cy: i_cell_y, cx: i_cell_x};
        end
        if (w_acc && w_kind == K_START) begin
            r_src <= '{cz: i_cell_z, cy: i_cell_y, cx: i_cell_x};
            r_n   <= (i_count > LEN_W'(MAX_STREAMS)) ? SIZE_W'(MAX_STREAMS) : i_count[SIZE_W-1:0];
            r_i   <= '0;
        end
        unique case (r_state)
            ST_INIT: begin
                r_s   <= r_i[STREAM_W-1:0];
                r_pos <= '0;
                r_ret <= ST_PUSH;
                r_h   <= r_heap_size[SIZE_W-1:1];
            end
            ST_PUSH: begin
                if (r_found) begin
                    r_heap_list[r_heap_size[STREAM_W-1:0]] <= r_i[STREAM_W-1:0];
                    r_heap_pos[r_heap_size[STREAM_W-1:0]]  <= r_pos[POS_W-1:0];
                end
                r_i <= r_i + SIZE_W'(1);
            end
            ST_HEAP: begin
                if (r_h != '0) begin
                    r_par <= r_h - HALF_W'(1);
                    r_h   <= r_h - HALF_W'(1);
                    r_ret <= ST_HEAP;
                end
            end
            ST_NX0: begin
                if (r_heap_size == '0) begin
                    r_cand <= '0;
                    r_exh  <= 1'b1;
                end
            end
            ST_NX1: begin
                r_cand <= r_lrd;
                r_exh  <= 1'b0;
                r_s    <= r_heap_list[0];
                r_pos  <= {1'b0, r_heap_pos[0]} + LEN_W'(1);
                r_ret  <= ST_NX2;
            end
            ST_NX2: begin
                if (r_found) begin
                    r_heap_pos[0] <= r_pos[POS_W-1:0];
                end else begin
                    r_heap_list[0] <= r_heap_list[r_heap_size[STREAM_W-1:0] - STREAM_W'(1)];
                    r_heap_pos[0]  <= r_heap_pos[r_heap_size[STREAM_W-1:0] - STREAM_W'(1)];
                end
            end
            ST_NX3: begin
                r_par <= '0;
                r_ret <= ST_DONE;
            end
            SK_CHK: begin
                if (r_pos >= r_list_len[r_s]) r_found <= 1'b0;
                else if (r_list_axes[r_s] == 3'b000) r_found <= 1'b1;
            end
            SK_CELL: begin
                if (w_own) r_found <= 1'b1;
                else r_pos <= r_pos + LEN_W'(1);
            end
            SF_N0: begin
                r_nl <= r_heap_list[r_par];
                r_np <= r_heap_pos[r_par];
            end
            SF_N2: begin
                r_node    <= r_meta;
                r_node_id <= r_lrd;
            end
            SF_C0: begin
                r_c <= w_c;
                if (w_c >= r_heap_size) begin
                    r_heap_list[r_par] <= r_nl;
                    r_heap_pos[r_par]  <= r_np;
                end
            end
            SF_C2: begin
                r_ka  <= r_meta;
                r_ida <= r_lrd;
            end
            SF_D2: begin
                if (w_b_first) begin
                    r_ka  <= r_meta;
                    r_ida <= r_lrd;
                    r_c   <= w_c1;
                end
            end
            SF_CMP: begin
                if (w_c_first) begin
                    r_heap_list[r_par] <= r_heap_list[r_c[STREAM_W-1:0]];
                    r_heap_pos[r_par]  <= r_heap_pos[r_c[STREAM_W-1:0]];
                    r_par <= r_c[STREAM_W-1:0];
                end else begin
                    r_heap_list[r_par] <= r_nl;
                    r_heap_pos[r_par]  <= r_np;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_valid;
    assign o_candidate = r_cand;
    assign o_exhausted = r_exh;

    `OCKM_IMPLIES(a_heap_bound, 1'b1, r_heap_size <= SIZE_W'(MAX_STREAMS))
    `OCKM_IMPLIES(a_exh_zero, o_valid && o_exhausted, o_candidate == '0)
    `OCKM_NEXT(a_next_busy, w_acc && w_kind == K_NEXT, busy)
    `OCKM_IMPLIES(a_sift_in_heap, r_state == SF_CMP, r_c < r_heap_size)

endmodule
